[sv/frac_pkg.sv]
// ----------------------------------------------------------------------------
// frac_pkg
// Shared types, widths and codes of the fraction arithmetic unit.
// ----------------------------------------------------------------------------
package frac_pkg;

  localparam int DW     = 32;
  localparam int CNT_W  = $clog2(DW + 1);
  localparam int STEP_W = 4;

  typedef logic signed [DW-1:0] word_t;

  typedef enum logic [3:0] {
    OP_REM         = 4'd0,
    OP_GCD         = 4'd1,
    OP_LCM         = 4'd2,
    OP_REDUCE      = 4'd3,
    OP_TO_MIXED    = 4'd4,
    OP_TO_IMPROPER = 4'd5,
    OP_ADD         = 4'd6,
    OP_SUB         = 4'd7,
    OP_MUL         = 4'd8,
    OP_DIV         = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_GCD,
    ST_GCD_WAIT,
    ST_DIV_WAIT
  } state_e;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    logic  div_zero;
    word_t quotient;
    word_t remainder;
  } div_rsp_t;

endpackage

[sv/frac_if.sv]
// ----------------------------------------------------------------------------
// frac_if
// Valid/ready channels carrying operation items and result items.
// ----------------------------------------------------------------------------
interface frac_in_if;
  logic             valid;
  logic             ready;
  logic [3:0]       operation;
  frac_pkg::word_t  operand_a;
  frac_pkg::word_t  operand_b;
  frac_pkg::word_t  operand_c;
  frac_pkg::word_t  operand_d;

  modport source (output valid, operation, operand_a, operand_b, operand_c, operand_d,
                  input ready);
  modport sink   (input valid, operation, operand_a, operand_b, operand_c, operand_d,
                  output ready);
endinterface

interface frac_out_if;
  logic             valid;
  logic             ready;
  frac_pkg::word_t  first_value;
  frac_pkg::word_t  second_value;
  frac_pkg::word_t  third_value;
  logic             divide_error;

  modport source (output valid, first_value, second_value, third_value, divide_error,
                  input ready);
  modport sink   (input valid, first_value, second_value, third_value, divide_error,
                  output ready);
endinterface

[sv/frac_div.sv]
// ----------------------------------------------------------------------------
// frac_div
// Shared bit-serial signed divider, truncating toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module frac_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frac_pkg::div_req_t req_i,
  output frac_pkg::div_rsp_t rsp_o
);
  import frac_pkg::*;

  logic             busy_q, done_q, dz_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    quo_q, rem_q, dmag_q;
  logic             neg_q_q, neg_r_q;
  logic [DW:0]      shifted, trial;
  logic [DW-1:0]    quo_nxt, rem_nxt, a_mag, b_mag;

  // operand magnitudes
  assign a_mag = req_i.dividend[DW-1] ? DW'(-req_i.dividend) : DW'(req_i.dividend);
  assign b_mag = req_i.divisor[DW-1]  ? DW'(-req_i.divisor)  : DW'(req_i.divisor);

  // restoring step
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    trial   = shifted - {1'b0, dmag_q};
    if (!trial[DW]) begin
      rem_nxt = trial[DW-1:0];
      quo_nxt = {quo_q[DW-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DW-1:0];
      quo_nxt = {quo_q[DW-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.divisor == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(DW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dz_q    <= (req_i.divisor == '0);
      quo_q   <= (req_i.divisor == '0) ? '0 : a_mag;
      rem_q   <= '0;
      dmag_q  <= b_mag;
      neg_q_q <= req_i.dividend[DW-1] ^ req_i.divisor[DW-1];
      neg_r_q <= req_i.dividend[DW-1];
    end else if (busy_q) begin
      quo_q <= quo_nxt;
      rem_q <= rem_nxt;
    end
  end

  // signed results
  assign rsp_o.done      = done_q;
  assign rsp_o.div_zero  = dz_q;
  assign rsp_o.quotient  = neg_q_q ? word_t'(-quo_q) : word_t'(quo_q);
  assign rsp_o.remainder = neg_r_q ? word_t'(-rem_q) : word_t'(rem_q);

endmodule

[sv/fraction_arithmetic_unit.sv]
// Gcd runs one divide per Euclid step, so items with long gcd chains take longest;
// unused codes finish without using the divider or the multiplier.
// The unit takes one item at a time; the shared bit-serial divider sets the pace.
// A new item is taken while a finished result still waits at the output.
// Reset (asynchronous, active low) returns the sequencer to idle, output empty.
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit
// Integer and fraction unit: sequencer over one divider and one multiplier.
// ----------------------------------------------------------------------------
module fraction_arithmetic_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  frac_in_if.sink     in_i,
  frac_out_if.source  out_o
);
  import frac_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  op_e               op_q;
  word_t             a_q, b_q, c_q, d_q;
  word_t             x_q, x_d, y_q, y_d, q_q, q_d, r_q, r_d, p_q, p_d;
  word_t             res0_q, res0_d, res1_q, res1_d, res2_q, res2_d;
  logic              fault_q, fault_d;
  logic              ov_q, ov_d;
  word_t             o0_q, o1_q, o2_q;
  logic              oe_q;
  logic              fin, mul_en, accept, load_out;
  word_t             mul_a, mul_b;
  div_req_t          dreq;
  div_rsp_t          drsp;

  frac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // sequencer
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    x_d          = x_q;
    y_d          = y_q;
    q_d          = q_q;
    r_d          = r_q;
    res0_d       = res0_q;
    res1_d       = res1_q;
    res2_d       = res2_q;
    fault_d      = fault_q;
    fin          = 1'b0;
    mul_en       = 1'b0;
    mul_a        = a_q;
    mul_b        = c_q;
    dreq.start    = 1'b0;
    dreq.dividend = x_q;
    dreq.divisor  = y_q;
    load_out     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          step_d  = '0;
          fault_d = 1'b0;
          res0_d  = '0;
          res1_d  = '0;
          res2_d  = '0;
        end
      end
      ST_RUN: begin
        step_d = step_q + 1'b1;
        case (op_q)
          OP_REM: begin
            case (step_q)
              4'd0: begin
                dreq = '{1'b1, a_q, b_q}; state_d = ST_DIV_WAIT;
              end
              default: begin res0_d = r_q; fin = 1'b1; end
            endcase
          end
          OP_GCD: begin
            case (step_q)
              4'd0: begin x_d = a_q; y_d = b_q; state_d = ST_GCD; end
              default: begin res0_d = x_q; fin = 1'b1; end
            endcase
          end
          OP_LCM: begin
            case (step_q)
              4'd0: begin x_d = a_q; y_d = b_q; state_d = ST_GCD; end
              4'd1: begin mul_en = 1'b1; mul_a = a_q; mul_b = b_q; end
              4'd2: begin dreq = '{1'b1, p_q, x_q}; state_d = ST_DIV_WAIT; end
              default: begin res0_d = q_q; fin = 1'b1; end
            endcase
          end
          OP_REDUCE: begin
            case (step_q)
              4'd0: begin x_d = a_q; y_d = b_q; state_d = ST_GCD; end
              4'd1: begin
                res2_d = x_q; dreq = '{1'b1, a_q, x_q}; state_d = ST_DIV_WAIT;
              end
              4'd2: begin
                res0_d = q_q; dreq = '{1'b1, b_q, res2_q}; state_d = ST_DIV_WAIT;
              end
              default: begin res1_d = q_q; fin = 1'b1; end
            endcase
          end
          OP_TO_MIXED: begin
            case (step_q)
              4'd0: begin dreq = '{1'b1, a_q, b_q}; state_d = ST_DIV_WAIT; end
              default: begin
                res0_d = q_q; res1_d = r_q; res2_d = b_q; fin = 1'b1;
              end
            endcase
          end
          OP_TO_IMPROPER: begin
            case (step_q)
              4'd0: begin mul_en = 1'b1; mul_a = c_q; mul_b = a_q; end
              default: begin res0_d = p_q + b_q; res1_d = c_q; fin = 1'b1; end
            endcase
          end
          OP_ADD, OP_SUB: begin
            case (step_q)
              4'd0: begin x_d = b_q; y_d = d_q; state_d = ST_GCD; end
              4'd1: begin mul_en = 1'b1; mul_a = b_q; mul_b = d_q; end
              4'd2: begin dreq = '{1'b1, p_q, x_q}; state_d = ST_DIV_WAIT; end
              4'd3: begin
                res1_d = q_q; dreq = '{1'b1, q_q, b_q}; state_d = ST_DIV_WAIT;
              end
              4'd4: begin mul_en = 1'b1; mul_a = a_q; mul_b = q_q; end
              4'd5: begin
                res0_d = p_q; dreq = '{1'b1, res1_q, d_q}; state_d = ST_DIV_WAIT;
              end
              4'd6: begin mul_en = 1'b1; mul_a = c_q; mul_b = q_q; end
              4'd7: res0_d = (op_q == OP_ADD) ? res0_q + p_q : res0_q - p_q;
              4'd8: begin x_d = res0_q; y_d = res1_q; state_d = ST_GCD; end
              default: begin res2_d = x_q; fin = 1'b1; end
            endcase
          end
          OP_MUL, OP_DIV: begin
            case (step_q)
              4'd0: begin
                mul_en = 1'b1; mul_a = a_q; mul_b = (op_q == OP_MUL) ? c_q : d_q;
              end
              4'd1: begin
                res0_d = p_q;
                mul_en = 1'b1; mul_a = b_q; mul_b = (op_q == OP_MUL) ? d_q : c_q;
              end
              4'd2: begin
                res1_d = p_q; x_d = res0_q; y_d = p_q; state_d = ST_GCD;
              end
              default: begin res2_d = x_q; fin = 1'b1; end
            endcase
          end
          default: fin = 1'b1;
        endcase
        // hand the item to the output stage once it is free
        if (fin) begin
          step_d = step_q;
          if (!ov_q || out_o.ready) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_GCD: begin
        if (y_q == '0) begin
          state_d = ST_RUN;
        end else begin
          dreq    = '{1'b1, x_q, y_q};
          state_d = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (drsp.done) begin
          x_d     = y_q;
          y_d     = drsp.remainder;
          state_d = ST_GCD;
        end
      end
      ST_DIV_WAIT: begin
        if (drsp.done) begin
          q_d     = drsp.quotient;
          r_d     = drsp.remainder;
          fault_d = fault_q | drsp.div_zero;
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // shared multiplier, low word kept
  assign p_d = mul_en ? word_t'(mul_a * mul_b) : p_q;

  // output valid
  always_comb begin
    ov_d = ov_q;
    if (out_o.ready) ov_d = 1'b0;
    if (load_out)    ov_d = 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      fault_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      fault_q <= fault_d;
      ov_q    <= ov_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_e'(in_i.operation);
      a_q  <= in_i.operand_a;
      b_q  <= in_i.operand_b;
      c_q  <= in_i.operand_c;
      d_q  <= in_i.operand_d;
    end
    x_q    <= x_d;
    y_q    <= y_d;
    q_q    <= q_d;
    r_q    <= r_d;
    p_q    <= p_d;
    res0_q <= res0_d;
    res1_q <= res1_d;
    res2_q <= res2_d;
    if (load_out) begin
      o0_q <= fault_q ? '0 : res0_d;
      o1_q <= fault_q ? '0 : res1_d;
      o2_q <= fault_q ? '0 : res2_d;
      oe_q <= fault_q;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.first_value  = o0_q;
  assign out_o.second_value = o1_q;
  assign out_o.third_value  = o2_q;
  assign out_o.divide_error = oe_q;

endmodule

[sv/frac_chk.sv]
// ----------------------------------------------------------------------------
// frac_chk
// Port-level checks of the fraction arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module frac_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input frac_pkg::word_t first_value_i,
  input frac_pkg::word_t second_value_i,
  input frac_pkg::word_t third_value_i,
  input logic            divide_error_i
);

  // a faulted item carries all-zero values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && divide_error_i |->
      first_value_i == '0 && second_value_i == '0 && third_value_i == '0)
    else $error("divide error with nonzero values");

  // a stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(first_value_i) &&
      $stable(second_value_i) && $stable(third_value_i) && $stable(divide_error_i))
    else $error("stalled output item changed");

  // an accepted item keeps the unit busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after accept");

endmodule

bind fraction_arithmetic_unit frac_chk u_frac_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .first_value_i  (out_o.first_value),
  .second_value_i (out_o.second_value),
  .third_value_i  (out_o.third_value),
  .divide_error_i (out_o.divide_error)
);

[dv/fraction_arithmetic_unit_tb.sv]
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit_tb
// Drives operation items with random gaps, predicts every result in the
// testbench and checks each output item field by field, in order.
// ----------------------------------------------------------------------------
module fraction_arithmetic_unit_tb;
  import frac_pkg::*;

  localparam logic [3:0] OP_SPARE_LO = 4'd10;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam int         RAND_ITEMS  = 1925;
  localparam int         IDLE_LIMIT  = 60000;
  localparam int         HOLD_AT     = 300;
  localparam int         HOLD_LEN    = 2500;
  localparam int         DRAIN_AT    = 1000;
  localparam word_t      W_MIN       = 32'sh8000_0000;
  localparam word_t      W_MAX       = 32'sh7fff_ffff;

  typedef struct {
    logic [3:0] op;
    word_t      a, b, c, d;
    bit         drain;
  } op_item_t;

  typedef struct {
    word_t first, second, third;
    logic  err;
  } frac_res_t;

  logic clk_i;
  logic rst_ni;

  frac_in_if  in_i ();
  frac_out_if out_o ();

  fraction_arithmetic_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i.sink),
    .out_o  (out_o.source)
  );

  op_item_t  pending_ops[$];
  frac_res_t expected_res[$];
  op_item_t  cur_op;
  int        accept_cnt = 0;
  int        sent_cnt   = 0;
  int        result_cnt = 0;
  int        error_cnt  = 0;
  int        idle_cycles = 0;
  bit        calm = 0;
  bit        div_fault;

  // clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic logic [31:0] mag(logic [31:0] x);
    return x[31] ? -x : x;
  endfunction

  function logic [31:0] sdiv(logic [31:0] x, logic [31:0] y);
    logic [31:0] q;
    if (y == 0) begin
      div_fault = 1;
      return 0;
    end
    q = mag(x) / mag(y);
    return (x[31] != y[31]) ? -q : q;
  endfunction

  function logic [31:0] srem(logic [31:0] x, logic [31:0] y);
    logic [31:0] r;
    if (y == 0) begin
      div_fault = 1;
      return 0;
    end
    r = mag(x) % mag(y);
    return x[31] ? -r : r;
  endfunction

  function logic [31:0] euclid(logic [31:0] x, logic [31:0] y);
    logic [31:0] t;
    while (y != 0) begin
      t = y;
      y = srem(x, y);
      x = t;
    end
    return x;
  endfunction

  function logic [31:0] lcm_of(logic [31:0] x, logic [31:0] y);
    return sdiv(x * y, euclid(x, y));
  endfunction

  function frac_res_t predict_fraction(op_item_t it);
    frac_res_t   r;
    logic [31:0] n, m, cd;
    r = '{0, 0, 0, 0};
    div_fault = 0;
    case (it.op)
      OP_REM: r.first = srem(it.a, it.b);
      OP_GCD: r.first = euclid(it.a, it.b);
      OP_LCM: r.first = lcm_of(it.a, it.b);
      OP_REDUCE: begin
        r.third  = euclid(it.a, it.b);
        r.first  = sdiv(it.a, r.third);
        r.second = sdiv(it.b, r.third);
      end
      OP_TO_MIXED: begin
        r.first  = sdiv(it.a, it.b);
        r.second = srem(it.a, it.b);
        r.third  = it.b;
      end
      OP_TO_IMPROPER: begin
        r.first  = it.c * it.a + it.b;
        r.second = it.c;
      end
      OP_ADD, OP_SUB: begin
        cd = lcm_of(it.b, it.d);
        n  = it.a * sdiv(cd, it.b);
        m  = it.c * sdiv(cd, it.d);
        n  = (it.op == OP_ADD) ? n + m : n - m;
        r.first  = n;
        r.second = cd;
        r.third  = euclid(n, cd);
      end
      OP_MUL, OP_DIV: begin
        n = (it.op == OP_MUL) ? it.a * it.c : it.a * it.d;
        m = (it.op == OP_MUL) ? it.b * it.d : it.b * it.c;
        r.first  = n;
        r.second = m;
        r.third  = euclid(n, m);
      end
      default: ;
    endcase
    if (div_fault) begin
      r.first  = 0;
      r.second = 0;
      r.third  = 0;
    end
    r.err = div_fault;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic word_t rand_operand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $signed($urandom_range(0, 40)) - 20;
    if (r < 60) return $signed($urandom_range(0, 2000)) - 1000;
    if (r < 68) return W_MIN;
    if (r < 74) return W_MAX;
    if (r < 78) return -1;
    return $urandom;
  endfunction

  task automatic add_op(logic [3:0] op, word_t a, word_t b, word_t c, word_t d,
                        bit drain = 0);
    op_item_t it;
    it = '{op, a, b, c, d, drain};
    pending_ops.push_back(it);
  endtask

  // ---------------- input driver ----------------
  int in_gap = 0;
  always @(negedge clk_i) begin
    bit busy;
    logic v;
    busy = in_i.valid;
    if (in_i.valid && accept_cnt != sent_cnt) begin
      sent_cnt++;
      busy = 0;
    end
    v = busy;
    if (!busy && rst_ni) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_ops.size() > 0 &&
                   !(pending_ops[0].drain && expected_res.size() != 0)) begin
        cur_op = pending_ops.pop_front();
        in_i.operation = cur_op.op;
        in_i.operand_a = cur_op.a;
        in_i.operand_b = cur_op.b;
        in_i.operand_c = cur_op.c;
        in_i.operand_d = cur_op.d;
        v = 1;
        in_gap = pick_gap();
      end
    end
    in_i.valid = v;
  end

  // ---------------- output receiver ----------------
  int  out_hold = 0;
  bit  held_once = 0;
  always @(negedge clk_i) begin
    logic rdy;
    if (!held_once && result_cnt >= HOLD_AT) begin
      held_once = 1;
      out_hold = HOLD_LEN;
    end
    if (out_hold > 0) begin
      out_hold--;
      rdy = 0;
    end else if (calm) begin
      rdy = 1;
    end else begin
      out_hold = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      rdy = (out_hold == 0);
    end
    out_o.ready = rdy;
  end

  // ---------------- monitors and watchdog ----------------
  always @(posedge clk_i) begin
    frac_res_t e;
    bit any;
    any = 0;
    if (rst_ni && in_i.valid && in_i.ready) begin
      expected_res.push_back(predict_fraction(cur_op));
      accept_cnt++;
      any = 1;
    end
    if (rst_ni && out_o.valid && out_o.ready) begin
      any = 1;
      result_cnt++;
      if (expected_res.size() == 0) begin
        $error("result item with no expectation waiting");
        error_cnt++;
      end else begin
        e = expected_res.pop_front();
        if (out_o.first_value !== e.first) begin
          $error("first_value expected %0d actual %0d", e.first, out_o.first_value);
          error_cnt++;
        end
        if (out_o.second_value !== e.second) begin
          $error("second_value expected %0d actual %0d", e.second, out_o.second_value);
          error_cnt++;
        end
        if (out_o.third_value !== e.third) begin
          $error("third_value expected %0d actual %0d", e.third, out_o.third_value);
          error_cnt++;
        end
        if (out_o.divide_error !== e.err) begin
          $error("divide_error expected %0b actual %0b", e.err, out_o.divide_error);
          error_cnt++;
        end
      end
    end
    idle_cycles = any ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    in_i.valid     = 0;
    in_i.operation = OP_REM;
    in_i.operand_a = 0;
    in_i.operand_b = 0;
    in_i.operand_c = 0;
    in_i.operand_d = 0;
    out_o.ready    = 0;
    rst_ni         = 0;

    // directed: extremes, each operation, zero divisors, min / -1
    add_op(OP_REM, 17, 5, 0, 0);
    add_op(OP_REM, 7, 0, 0, 0);
    add_op(OP_REM, W_MIN, -1, 0, 0);
    add_op(OP_GCD, 0, 0, 0, 0);
    add_op(OP_GCD, -48, 18, 0, 0);
    add_op(OP_GCD, W_MIN, W_MAX, 0, 0);
    add_op(OP_LCM, 0, 0, 0, 0);
    add_op(OP_LCM, 6, -4, 0, 0);
    add_op(OP_REDUCE, 0, 0, 0, 0);
    add_op(OP_REDUCE, 12, -18, 0, 0);
    add_op(OP_TO_MIXED, 7, 0, 0, 0);
    add_op(OP_TO_MIXED, W_MIN, -1, 0, 0);
    add_op(OP_TO_MIXED, -7, 2, 0, 0);
    add_op(OP_TO_IMPROPER, 3, 1, 4, 0);
    add_op(OP_TO_IMPROPER, W_MAX, W_MAX, W_MAX, 0);
    add_op(OP_ADD, 1, 0, 1, 3);
    add_op(OP_ADD, 1, 2, 1, 0);
    add_op(OP_ADD, 1, 6, 1, 4, 1);
    add_op(OP_SUB, 1, 6, 1, 4);
    add_op(OP_SUB, W_MIN, -1, W_MAX, -1);
    add_op(OP_MUL, 2, 0, 3, 5);
    add_op(OP_MUL, W_MIN, W_MIN, W_MIN, W_MIN);
    add_op(OP_DIV, -1, -1, -1, -1);
    add_op(OP_DIV, 2, 3, 0, 4);
    add_op(OP_SPARE_LO, 5, 6, 7, 8);
    add_op(OP_SPARE_HI, W_MAX, W_MIN, -1, 1);

    // random: mostly real operations, a few spare codes
    for (int i = 0; i < RAND_ITEMS; i++) begin
      logic [3:0] op;
      op = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                        : 4'($urandom_range(OP_REM, OP_DIV));
      add_op(op, rand_operand(), rand_operand(), rand_operand(), rand_operand(),
             i == DRAIN_AT);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // a stretch without idling on either side
    wait (accept_cnt >= 600);
    calm = 1;
    wait (accept_cnt >= 800);
    calm = 0;

    wait (pending_ops.size() == 0 && !in_i.valid && expected_res.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_cnt == 0 && expected_res.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
sv/frac_pkg.sv
sv/frac_if.sv
sv/frac_div.sv
sv/fraction_arithmetic_unit.sv
sv/frac_chk.sv
dv/fraction_arithmetic_unit_tb.sv
